// ===== src/cpd_pkg.sv =====
// Shared types and constants for the closest pair distance block.
package cpd_pkg;

  localparam int COORD_W         = 16;
  localparam int DIST_W          = 2 * COORD_W + 1;
  localparam int MAX_POINTS_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_point;
  } in_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_sq_dist;
    logic              no_pair;
    logic              overflowed;
  } out_req_t;

  typedef struct packed {
    logic    valid;
    in_req_t req;
  } q_head_t;

endpackage

// ===== src/cpd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cpd_ram import cpd_pkg::*; #(
  parameter int WIDTH = 2 * COORD_W,
  parameter int DEPTH = MAX_POINTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cpd_queue.sv =====
// Front queue that accepts point requests and hands them to the compare engine.
module cpd_queue import cpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  in_req_t req_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  in_req_t       mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    cnt_d = cnt_q + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= req_i;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = mem_q[rptr_q];

endmodule

// ===== src/cpd_engine.sv =====
// Back end that sweeps the point store, tracks the running minimum and issues results.
module cpd_engine import cpd_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_head_t  q_head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = 2 * COORD_W;
  localparam int SW = 2 * COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e            state_q, state_d;
  in_req_t           cur_q, cur_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;
  logic [DIST_W-1:0] min_q, min_d;
  logic              ovf_q, ovf_d;
  logic              rd_v_q, diff_v_q, sq_v_q;
  logic [COORD_W-1:0] adx_q, ady_q;
  logic [COORD_W-1:0] adx_d, ady_d;
  logic [SW-1:0]     sqx_q, sqy_q;
  logic              out_valid_q, out_valid_d;
  out_req_t          out_q, out_d;

  logic              ram_re, ram_we;
  logic [RW-1:0]     ram_rdata;
  logic [COORD_W-1:0] sx, sy;
  logic [COORD_W:0]  dx, dy;
  logic [DIST_W-1:0] sq_sum;
  logic [CW-1:0]     count_next;
  logic              room, out_free, finish;

  cpd_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({cur_q.x_coord, cur_q.y_coord}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign sx = ram_rdata[RW-1:COORD_W];
  assign sy = ram_rdata[COORD_W-1:0];

  always_comb begin
    dx    = {cur_q.x_coord[COORD_W-1], cur_q.x_coord} - {sx[COORD_W-1], sx};
    dy    = {cur_q.y_coord[COORD_W-1], cur_q.y_coord} - {sy[COORD_W-1], sy};
    adx_d = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady_d = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  end

  assign sq_sum     = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign room       = (count_q < CW'(MAX_POINTS));
  assign count_next = room ? count_q + CW'(1) : count_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_DRAIN) && !rd_v_q && !diff_v_q && !sq_v_q &&
                      (!cur_q.last_point || out_free);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    count_d     = count_q;
    min_d       = min_q;
    ovf_d       = ovf_q;
    pop_o       = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (sq_v_q && (sq_sum < min_q)) begin
      min_d = sq_sum;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_head_i.valid) begin
          pop_o   = 1'b1;
          cur_d   = q_head_i.req;
          idx_d   = '0;
          state_d = (count_q == '0) ? ST_DRAIN : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        ram_re = 1'b1;
        idx_d  = idx_q + AW'(1);
        if (CW'(idx_q) == count_q - CW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          ram_we  = room;
          count_d = count_next;
          ovf_d   = ovf_q | !room;
          state_d = ST_IDLE;
          if (cur_q.last_point) begin
            out_valid_d       = 1'b1;
            out_d.no_pair     = (count_next < CW'(2));
            out_d.min_sq_dist = (count_next < CW'(2)) ? '0 : min_q;
            out_d.overflowed  = ovf_q | !room;
            count_d           = '0;
            min_d             = '1;
            ovf_d             = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      min_q       <= '1;
      ovf_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      diff_v_q    <= 1'b0;
      sq_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      min_q       <= min_d;
      ovf_q       <= ovf_d;
      rd_v_q      <= ram_re;
      diff_v_q    <= rd_v_q;
      sq_v_q      <= diff_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
    adx_q <= adx_d;
    ady_q <= ady_d;
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== src/closest_pair_distance.sv =====
// Top level of the closest pair distance block: front queue, compare engine and point store.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      in_valid_i / in_stall_o      in_req_i  (x_coord, y_coord, last_point)
//   out      output     out_valid_o / out_stall_i    out_req_o (min_sq_dist, no_pair, overflowed)
//
// A point request is swept against every point already stored in the set, and goes straight
// to the drain state when the store is empty; the sweep reads one stored point per cycle
// from the single read port of the point RAM, followed by a three-stage difference, square
// and compare pipe.
// Reset clears the counters and flags at once; the point store is not cleared.
// The front queue keeps taking requests while the engine sweeps, and the output register
// holds a result under out_stall_i; the engine waits only when a new result would replace it.
module closest_pair_distance import cpd_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  q_head_t q_head;
  logic    q_full;
  logic    eng_pop;

  assign in_stall_o = q_full;

  cpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .req_i  (in_req_i),
    .full_o (q_full),
    .pop_i  (eng_pop),
    .head_o (q_head)
  );

  cpd_engine #(
    .MAX_POINTS (MAX_POINTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_head_i    (q_head),
    .pop_o       (eng_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_pop |-> q_head.valid)
    else $error("Engine popped an empty queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> q_head.valid)
    else $error("Accepted request did not reach the queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.no_pair) |-> (out_req_o.min_sq_dist == '0))
    else $error("Result without a pair carries a nonzero distance.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.overflowed) |-> !out_req_o.no_pair)
    else $error("Overflowed set reported as having no pair.");
`endif

endmodule
